// File: design/fcm_pkg.sv
// Package for the fixed capacity multiset: sizes, opcodes, status codes, state encoding.
package fcm_pkg;

	localparam int CAPACITY    = 32;
	localparam int VALUE_WIDTH = 32;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	localparam int OPCODE_W = 2;
	localparam int ITEM_W   = 32;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 6;
	localparam int FILL_W   = 6;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT    = 2'd0,
		OP_COUNT     = 2'd1,
		OP_ERASE_ONE = 2'd2,
		OP_ERASE_ALL = 2'd3
	} fcm_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2
	} fcm_status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} fcm_state_t;

endpackage

// File: design/fcm_cmd_if.sv
// Command channel: opcode and value with valid/ready handshake.
interface fcm_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [fcm_pkg::OPCODE_W-1:0] opcode;
	logic [fcm_pkg::ITEM_W-1:0]   item_value;

	modport source (output valid, output opcode, output item_value, input ready);
	modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

// File: design/fcm_rsp_if.sv
// Response channel: status, match total and fill level with valid/ready handshake.
interface fcm_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [fcm_pkg::STATUS_W-1:0] status;
	logic [fcm_pkg::TOTAL_W-1:0]  match_total;
	logic [fcm_pkg::FILL_W-1:0]   fill_level;

	modport source (output valid, output status, output match_total, output fill_level,
		input ready);
	modport sink   (input valid, input status, input match_total, input fill_level,
		output ready);
endinterface

// File: design/fixed_capacity_multiset.sv
// Fixed capacity multiset (bag) of values: insert, count, erase one match, erase all matches.
// Entries sit unordered in one RAM with a fill count. Insert writes at the fill count and
// passes through the finish state back to idle. Count and both erases scan the filled
// entries: one shared compare unit walks the RAM read port one entry a cycle, and the erases
// compact the survivors in place through the write port as the scan goes, so the bag is
// rewritten in the same pass. Only one command is in flight at a time; the response sits in
// an output register, so the next command is taken while it waits.
module fixed_capacity_multiset (
	input  logic      clk,
	input  logic      arst_n,
	fcm_cmd_if.sink   cmd,
	fcm_rsp_if.source rsp
);

	fcm_pkg::fcm_state_t  state_q;
	fcm_pkg::fcm_op_t     op_q;
	fcm_pkg::fcm_status_t status_q;
	logic [fcm_pkg::VALUE_WIDTH-1:0] val_q;
	logic [fcm_pkg::CNT_W-1:0]       cnt_q;
	logic [fcm_pkg::CNT_W-1:0]       rd_q;
	logic [fcm_pkg::CNT_W-1:0]       wr_q;
	logic [fcm_pkg::CNT_W-1:0]       total_q;
	logic                            dropped_q;
	logic                            rd_vld_s1;

	logic                         rsp_vld_q;
	logic [fcm_pkg::STATUS_W-1:0] rsp_status_q;
	logic [fcm_pkg::TOTAL_W-1:0]  rsp_total_q;
	logic [fcm_pkg::FILL_W-1:0]   rsp_fill_q;

	fcm_pkg::fcm_op_t                cmd_op;
	logic [fcm_pkg::VALUE_WIDTH-1:0] cmd_val;
	logic                            accept;
	logic                            is_full;
	logic                            read_go;
	logic                            match;
	logic                            drop;
	logic                            keep_wr;
	logic                            hit;
	logic                            scan_done;
	logic                            load_rsp;

	logic                            ram_we;
	logic [fcm_pkg::ADDR_W-1:0]      ram_waddr;
	logic [fcm_pkg::VALUE_WIDTH-1:0] ram_wdata;
	logic [fcm_pkg::ADDR_W-1:0]      ram_raddr;
	logic [fcm_pkg::VALUE_WIDTH-1:0] ram_rdata;

	assign cmd.ready = (state_q == fcm_pkg::S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign cmd_op    = fcm_pkg::fcm_op_t'(cmd.opcode);
	assign cmd_val   = fcm_pkg::VALUE_WIDTH'(cmd.item_value);
	assign is_full   = (cnt_q == fcm_pkg::CNT_W'(fcm_pkg::CAPACITY));

	assign read_go   = (state_q == fcm_pkg::S_SCAN) && (rd_q != cnt_q);
	assign ram_raddr = rd_q[fcm_pkg::ADDR_W-1:0];

	// shared compare on the value coming out of the RAM
	assign match   = rd_vld_s1 && (ram_rdata == val_q);
	assign drop    = match && ((op_q == fcm_pkg::OP_ERASE_ALL) ||
		((op_q == fcm_pkg::OP_ERASE_ONE) && !dropped_q));
	assign keep_wr = rd_vld_s1 && !drop && (op_q != fcm_pkg::OP_COUNT);
	assign hit     = drop || (match && (op_q == fcm_pkg::OP_COUNT));

	// last read has been compared once the pipe is empty at the end of the fill
	assign scan_done = (state_q == fcm_pkg::S_SCAN) && (rd_q == cnt_q) && !rd_vld_s1;
	assign load_rsp  = (state_q == fcm_pkg::S_FINISH) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[fcm_pkg::ADDR_W-1:0];
		ram_wdata = ram_rdata;
		if (accept && (cmd_op == fcm_pkg::OP_INSERT) && !is_full) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[fcm_pkg::ADDR_W-1:0];
			ram_wdata = cmd_val;
		end else if (keep_wr) begin
			// compact: survivors slide down to the write pointer
			ram_we = 1'b1;
		end
	end

	fcm_ram #(
		.WIDTH(fcm_pkg::VALUE_WIDTH),
		.DEPTH(fcm_pkg::CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fcm_pkg::S_IDLE;
			cnt_q     <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			total_q   <= '0;
			dropped_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			op_q      <= fcm_pkg::OP_INSERT;
			status_q  <= fcm_pkg::STS_OK;
			val_q     <= '0;
		end else begin
			unique case (state_q)
				fcm_pkg::S_IDLE: begin
					if (accept) begin
						op_q      <= cmd_op;
						val_q     <= cmd_val;
						rd_q      <= '0;
						wr_q      <= '0;
						dropped_q <= 1'b0;
						rd_vld_s1 <= 1'b0;
						status_q  <= fcm_pkg::STS_OK;
						total_q   <= '0;
						if (cmd_op == fcm_pkg::OP_INSERT) begin
							state_q <= fcm_pkg::S_FINISH;
							if (is_full) begin
								status_q <= fcm_pkg::STS_FULL;
							end else begin
								cnt_q   <= cnt_q + fcm_pkg::CNT_W'(1);
								total_q <= fcm_pkg::CNT_W'(1);
							end
						end else begin
							state_q <= fcm_pkg::S_SCAN;
						end
					end
				end
				fcm_pkg::S_SCAN: begin
					rd_vld_s1 <= read_go;
					if (read_go) begin
						rd_q <= rd_q + fcm_pkg::CNT_W'(1);
					end
					if (hit) begin
						total_q <= total_q + fcm_pkg::CNT_W'(1);
					end
					if (drop) begin
						dropped_q <= 1'b1;
					end
					if (keep_wr) begin
						wr_q <= wr_q + fcm_pkg::CNT_W'(1);
					end
					if (scan_done) begin
						state_q <= fcm_pkg::S_FINISH;
						if (op_q != fcm_pkg::OP_COUNT) begin
							cnt_q <= wr_q;
						end
						if ((op_q == fcm_pkg::OP_ERASE_ONE) && (total_q == '0)) begin
							status_q <= fcm_pkg::STS_NOT_FOUND;
						end
					end
				end
				fcm_pkg::S_FINISH: begin
					// hold until the response register is free
					if (load_rsp) begin
						state_q <= fcm_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= fcm_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_status_q <= status_q;
			rsp_total_q  <= fcm_pkg::TOTAL_W'(total_q);
			rsp_fill_q   <= fcm_pkg::FILL_W'(cnt_q);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.match_total = rsp_total_q;
	assign rsp.fill_level  = rsp_fill_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fcm_pkg::CNT_W'(fcm_pkg::CAPACITY))
		else $error("fill count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fcm_pkg::S_SCAN) |-> (wr_q <= rd_q && rd_q <= cnt_q))
		else $error("compaction write pointer passed read pointer");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == fcm_pkg::S_SCAN))
		else $error("read data in flight outside a scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		(load_rsp && (status_q != fcm_pkg::STS_OK)) |-> (total_q == '0))
		else $error("refused operation reports a nonzero total");

endmodule

// File: design/fcm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
